// File: rtl/assert_macros.svh
// Assertion macros for the JSON string unescape unit.
// Used by the top level; expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: rtl/jsu_pkg.sv
// Package for the JSON string unescape unit: types, character codes,
// error codes and UTF-8 / hex helper functions. No dependencies.
`default_nettype none

package jsu_pkg;

    // Result queue sizing; one item yields at most MAX_RES results.
    localparam int MAX_RES = 4;
    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Error codes.
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_ESCAPE  = 2'd1;
    localparam logic [1:0] ERR_HEX     = 2'd2;
    localparam logic [1:0] ERR_EOD     = 2'd3;

    // Character codes.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LN    = 8'h6E;
    localparam logic [7:0] CH_LR    = 8'h72;
    localparam logic [7:0] CH_LT    = 8'h74;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LU    = 8'h75;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_FF    = 8'h0C;

    // Surrogate ranges.
    localparam logic [15:0] HI_SUR_MIN = 16'hD800;
    localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
    localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    // UTF-8 lead and continuation marks.
    localparam logic [7:0] U8_LEAD2 = 8'hC0;
    localparam logic [7:0] U8_LEAD3 = 8'hE0;
    localparam logic [7:0] U8_LEAD4 = 8'hF0;
    localparam logic [7:0] U8_CONT  = 8'h80;

    typedef enum logic [2:0] {
        MODE_PLAIN = 3'b001,
        MODE_ESC   = 3'b010,
        MODE_HEX   = 3'b100
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [1:0]  hex_cnt;
        logic [15:0] acc;
        logic [15:0] held;
        logic        held_v;
    } state_t;

    localparam state_t ST_RESET = '{
        mode:    MODE_PLAIN,
        hex_cnt: 2'd0,
        acc:     16'd0,
        held:    16'd0,
        held_v:  1'b0
    };

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_done;
        logic [1:0] error_code;
        logic       last_of_run;
    } res_t;

    localparam res_t RES_ZERO = '0;

    // Results of one item, entry 0 first.
    typedef struct packed {
        logic [2:0]             cnt;
        res_t [MAX_RES-1:0]     ent;
    } grp_t;

    typedef struct packed {
        logic [2:0]       n;
        logic [3:0][7:0]  b;
    } utf8_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] ch;
    } esc_t;

    function automatic hex_t hex_value(logic [7:0] c);
        hex_t r;
        r = '0;
        case (c) inside
            [CH_0:CH_9]:   begin r.ok = 1'b1; r.val = 4'(c - CH_0); end
            [CH_UA:CH_UF]: begin r.ok = 1'b1; r.val = 4'(c - CH_UA + 8'd10); end
            [CH_LA:CH_LF]: begin r.ok = 1'b1; r.val = 4'(c - CH_LA + 8'd10); end
            default:       r = '0;
        endcase
        return r;
    endfunction

    function automatic esc_t esc_char(logic [7:0] c);
        esc_t r;
        r = '{ok: 1'b1, ch: c};
        case (c) inside
            CH_QUOTE, CH_BSL, CH_SLASH: r.ch = c;
            CH_LN:   r.ch = CH_NL;
            CH_LR:   r.ch = CH_CR;
            CH_LT:   r.ch = CH_TAB;
            CH_LB:   r.ch = CH_BS;
            CH_LF:   r.ch = CH_FF;
            default: r = '0;
        endcase
        return r;
    endfunction

    // UTF-8 of a 16-bit code: one to three bytes.
    function automatic utf8_t utf8_enc16(logic [15:0] c);
        utf8_t r;
        r = '0;
        if (c < 16'h0080) begin
            r.n    = 3'd1;
            r.b[0] = c[7:0];
        end
        else if (c < 16'h0800) begin
            r.n    = 3'd2;
            r.b[0] = U8_LEAD2 | {3'b000, c[10:6]};
            r.b[1] = U8_CONT  | {2'b00, c[5:0]};
        end
        else begin
            r.n    = 3'd3;
            r.b[0] = U8_LEAD3 | {4'b0000, c[15:12]};
            r.b[1] = U8_CONT  | {2'b00, c[11:6]};
            r.b[2] = U8_CONT  | {2'b00, c[5:0]};
        end
        return r;
    endfunction

    // UTF-8 of a supplementary code point: always four bytes.
    function automatic utf8_t utf8_enc21(logic [20:0] cp);
        utf8_t r;
        r.n    = 3'd4;
        r.b[0] = U8_LEAD4 | {5'b00000, cp[20:18]};
        r.b[1] = U8_CONT  | {2'b00, cp[17:12]};
        r.b[2] = U8_CONT  | {2'b00, cp[11:6]};
        r.b[3] = U8_CONT  | {2'b00, cp[5:0]};
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/json_string_unescape_utf8_unit.sv
// JSON string unescape unit with UTF-8 output, top level.
// Depends on jsu_pkg, jsu_step, jsu_res_queue and assert_macros.svh.
//
// Usage:
//   Feed the bytes of a JSON string body (after the opening quote) on the
//   input channel (in_valid/in_ready, in_byte, end_of_data), one byte per
//   transfer. Results leave on the output channel (out_valid/out_ready) with
//   out_byte, byte_valid, string_done, error_code and last_of_run; every byte
//   that causes results marks its final one with last_of_run.
//   A byte's results enter the result queue when it transfers and leave in order.
//   Throughput: one byte per cycle while each byte yields at most one result and
//   the receiver takes results; a byte that yields more (up to four, e.g. a UTF-8
//   sequence after a \uXXXX escape) occupies the output until all have left;
//   the limit is the single output port draining an eight-entry result queue;
//   the input is accepted whenever at least four queue entries are free, so
//   input keeps flowing while results wait.
//   Receiver stall: results stay in the queue; once fewer than four entries
//   are free, in_ready drops until the receiver takes results.
//   Reset: the queue empties and the parser returns to plain text mode with
//   no held code; after an error or a closing quote it returns there too.
`default_nettype none

module json_string_unescape_utf8_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            string_done,
    output logic [1:0]      error_code,
    output logic            last_of_run
);

`include "assert_macros.svh"

    jsu_pkg::state_t st_reg;
    jsu_pkg::state_t st_next;
    jsu_pkg::grp_t   grp;
    jsu_pkg::res_t   head;
    logic            in_xfer;

    assign in_xfer = in_valid && in_ready;

    // Parse step: state plus incoming byte give next state and the result group.
    jsu_step u_step (
        .st          (st_reg),
        .in_byte     (in_byte),
        .end_of_data (end_of_data),
        .st_next     (st_next),
        .grp         (grp)
    );

    // Advance parser state only on an input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= jsu_pkg::ST_RESET;
        end
        else if (in_xfer)
        begin
            st_reg <= st_next;
        end
    end

    // Queue the group; an item with no result pushes nothing.
    jsu_res_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_xfer),
        .grp        (grp),
        .space      (in_ready),
        .head_valid (out_valid),
        .head_ready (out_ready),
        .head       (head)
    );

    assign out_byte    = head.out_byte;
    assign byte_valid  = head.byte_valid;
    assign string_done = head.string_done;
    assign error_code  = head.error_code;
    assign last_of_run = head.last_of_run;

    // An error result carries no byte and closes its run.
    `ASSERT_CLK(a_err_alone,
        (out_valid && error_code != jsu_pkg::ERR_NONE) |->
            (!byte_valid && !string_done && last_of_run && out_byte == 8'd0),
        "error result carries data or is not last")

    // The closing quote result is the last of its run and carries no byte.
    `ASSERT_NEVER(a_done_byte,
        out_valid && string_done && (byte_valid || !last_of_run),
        "string_done result malformed")

    // A closing quote in plain mode leaves nothing held.
    `ASSERT_CLK(a_quote_clears,
        (in_xfer && !end_of_data && st_reg.mode == jsu_pkg::MODE_PLAIN
            && in_byte == jsu_pkg::CH_QUOTE) |=>
            (st_reg == jsu_pkg::ST_RESET),
        "parser state not cleared after closing quote")

    // End of data returns the parser to its reset state.
    `ASSERT_CLK(a_eod_clears,
        (in_xfer && end_of_data) |=> (st_reg == jsu_pkg::ST_RESET),
        "parser state not cleared after end of data")

endmodule

`default_nettype wire

// File: rtl/jsu_step.sv
// Next-state and result logic for one input byte of the unescape unit.
// Depends on jsu_pkg.
`default_nettype none

module jsu_step (
    input  var jsu_pkg::state_t st,
    input  wire logic [7:0]     in_byte,
    input  wire logic           end_of_data,
    output jsu_pkg::state_t     st_next,
    output jsu_pkg::grp_t       grp
);

    jsu_pkg::hex_t      hv;
    jsu_pkg::esc_t      ev;
    jsu_pkg::utf8_t     held_enc;
    jsu_pkg::utf8_t     pair_enc;
    logic [15:0]        acc_new;
    logic [20:0]        cp;
    logic               pair;
    logic [2:0]         flush_n;
    logic [2:0]         prefix_n;
    logic [3:0][7:0]    prefix_b;
    logic               extra_v;
    jsu_pkg::res_t      extra;
    logic [2:0]         grp_cnt;

    assign hv       = jsu_pkg::hex_value(in_byte);
    assign ev       = jsu_pkg::esc_char(in_byte);
    assign acc_new  = {st.acc[11:0], hv.val};
    assign held_enc = jsu_pkg::utf8_enc16(st.held);
    assign cp       = jsu_pkg::SUPP_BASE + {1'b0, st.held[9:0], acc_new[9:0]};
    assign pair_enc = jsu_pkg::utf8_enc21(cp);
    assign flush_n  = st.held_v ? held_enc.n : 3'd0;
    assign pair     = st.held_v
                      && st.held >= jsu_pkg::HI_SUR_MIN && st.held <= jsu_pkg::HI_SUR_MAX
                      && acc_new >= jsu_pkg::LO_SUR_MIN && acc_new <= jsu_pkg::LO_SUR_MAX;

    always_comb
    begin
        st_next  = st;
        prefix_n = 3'd0;
        prefix_b = held_enc.b;
        extra_v  = 1'b0;
        extra    = jsu_pkg::RES_ZERO;
        if (end_of_data)
        begin
            st_next          = jsu_pkg::ST_RESET;
            extra_v          = 1'b1;
            extra.error_code = jsu_pkg::ERR_EOD;
        end
        else
        begin
            case (st.mode)
                jsu_pkg::MODE_ESC:
                begin
                    if (in_byte == jsu_pkg::CH_LU)
                    begin
                        st_next.mode    = jsu_pkg::MODE_HEX;
                        st_next.hex_cnt = 2'd0;
                        st_next.acc     = 16'd0;
                    end
                    else if (ev.ok)
                    begin
                        prefix_n         = flush_n;
                        st_next.held_v   = 1'b0;
                        st_next.held     = 16'd0;
                        extra_v          = 1'b1;
                        extra.out_byte   = ev.ch;
                        extra.byte_valid = 1'b1;
                        st_next.mode     = jsu_pkg::MODE_PLAIN;
                    end
                    else
                    begin
                        st_next          = jsu_pkg::ST_RESET;
                        extra_v          = 1'b1;
                        extra.error_code = jsu_pkg::ERR_ESCAPE;
                    end
                end
                jsu_pkg::MODE_HEX:
                begin
                    if (!hv.ok)
                    begin
                        st_next          = jsu_pkg::ST_RESET;
                        extra_v          = 1'b1;
                        extra.error_code = jsu_pkg::ERR_HEX;
                    end
                    else if (st.hex_cnt == 2'd3)
                    begin
                        // Fourth digit: merge a surrogate pair or flush and hold.
                        if (pair)
                        begin
                            prefix_n       = pair_enc.n;
                            prefix_b       = pair_enc.b;
                            st_next.held_v = 1'b0;
                            st_next.held   = 16'd0;
                        end
                        else
                        begin
                            prefix_n       = flush_n;
                            st_next.held   = acc_new;
                            st_next.held_v = 1'b1;
                        end
                        st_next.mode    = jsu_pkg::MODE_PLAIN;
                        st_next.hex_cnt = 2'd0;
                        st_next.acc     = 16'd0;
                    end
                    else
                    begin
                        st_next.hex_cnt = st.hex_cnt + 2'd1;
                        st_next.acc     = acc_new;
                    end
                end
                jsu_pkg::MODE_PLAIN:
                begin
                    if (in_byte == jsu_pkg::CH_BSL)
                    begin
                        st_next.mode = jsu_pkg::MODE_ESC;
                    end
                    else
                    begin
                        prefix_n       = flush_n;
                        st_next.held_v = 1'b0;
                        st_next.held   = 16'd0;
                        extra_v        = 1'b1;
                        if (in_byte == jsu_pkg::CH_QUOTE)
                        begin
                            extra.string_done = 1'b1;
                            st_next           = jsu_pkg::ST_RESET;
                        end
                        else
                        begin
                            extra.out_byte   = in_byte;
                            extra.byte_valid = 1'b1;
                        end
                    end
                end
                default:
                begin
                    st_next = jsu_pkg::ST_RESET;
                end
            endcase
        end
    end

    // Pack prefix bytes then the trailing result; mark the final one.
    assign grp_cnt = prefix_n + {2'b00, extra_v};

    always_comb
    begin
        grp.cnt = grp_cnt;
        for (int i = 0; i < jsu_pkg::MAX_RES; i++)
        begin
            grp.ent[i] = jsu_pkg::RES_ZERO;
            if (3'(i) < prefix_n)
            begin
                grp.ent[i].out_byte   = prefix_b[i];
                grp.ent[i].byte_valid = 1'b1;
            end
            else if (3'(i) == prefix_n && extra_v)
            begin
                grp.ent[i] = extra;
            end
            if (grp_cnt != 3'd0 && 3'(i) == grp_cnt - 3'd1)
            begin
                grp.ent[i].last_of_run = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/jsu_res_queue.sv
// Result queue: takes up to four results per cycle, hands out one per transfer.
// Depends on jsu_pkg.
`default_nettype none

module jsu_res_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  var jsu_pkg::grp_t   grp,
    output logic                space,
    output logic                head_valid,
    input  wire logic           head_ready,
    output jsu_pkg::res_t       head
);

    jsu_pkg::res_t                  q_mem [jsu_pkg::Q_DEPTH];
    logic [jsu_pkg::Q_AW-1:0]       wr_reg;
    logic [jsu_pkg::Q_AW-1:0]       wr_next;
    logic [jsu_pkg::Q_AW-1:0]       rd_reg;
    logic [jsu_pkg::Q_AW-1:0]       rd_next;
    logic [jsu_pkg::Q_CW-1:0]       cnt_reg;
    logic [jsu_pkg::Q_CW-1:0]       cnt_next;
    logic [jsu_pkg::Q_CW-1:0]       push_n;
    logic                           pop;

    assign push_n     = push ? jsu_pkg::Q_CW'(grp.cnt) : '0;
    assign head_valid = (cnt_reg != '0);
    assign pop        = head_valid && head_ready;
    assign head       = q_mem[rd_reg];
    // Room for a worst-case item, judged on the registered count only.
    assign space      = (cnt_reg <= jsu_pkg::Q_CW'(jsu_pkg::Q_DEPTH - jsu_pkg::MAX_RES));

    assign wr_next  = wr_reg + jsu_pkg::Q_AW'(push_n);
    assign rd_next  = rd_reg + jsu_pkg::Q_AW'(pop);
    assign cnt_next = cnt_reg + push_n - jsu_pkg::Q_CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < jsu_pkg::MAX_RES; k++)
        begin
            if (push && 3'(k) < grp.cnt)
            begin
                q_mem[wr_reg + jsu_pkg::Q_AW'(k)] <= grp.ent[k];
            end
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for json_string_unescape_utf8_unit.
// Drives JSON string body bytes through the valid/ready input channel and checks every
// decoded result against a cycle-free predictor; depends on jsu_pkg and the unit RTL.
`timescale 1ns / 1ps

module testbench;

    // ------------------------------------------------------------------
    // Run shape
    // ------------------------------------------------------------------
    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 8;
    localparam int RAND_ITEMS   = 480;
    localparam int IDLE_PCT     = 37;        // chance of an idle cycle on either side
    localparam int CALM_LO      = 150;       // item window with no idling on either side
    localparam int CALM_HI      = 260;
    localparam int DRAIN_CYCLES = 16;        // extra wait for stray results after the last owed one
    localparam int WATCHDOG_NS  = 2_000_000;

    // One stimulus row: the byte, the end-of-data flag and, where the answer is
    // obvious, the single result typed in by hand.
    typedef struct packed {
        logic [7:0]    b;
        logic          eod;
        logic          typed;
        jsu_pkg::res_t want;
    } feed_t;

    // Hand-written results: last_of_run is always set since each is the only one.
    localparam jsu_pkg::res_t WANT_EOD     = '{8'h00, 1'b0, 1'b0, jsu_pkg::ERR_EOD,    1'b1};
    localparam jsu_pkg::res_t WANT_BAD_ESC = '{8'h00, 1'b0, 1'b0, jsu_pkg::ERR_ESCAPE, 1'b1};
    localparam jsu_pkg::res_t WANT_BAD_HEX = '{8'h00, 1'b0, 1'b0, jsu_pkg::ERR_HEX,    1'b1};
    localparam jsu_pkg::res_t WANT_DONE    = '{8'h00, 1'b0, 1'b1, jsu_pkg::ERR_NONE,   1'b1};
    localparam jsu_pkg::res_t WANT_NUL     = '{8'h00, 1'b1, 1'b0, jsu_pkg::ERR_NONE,   1'b1};
    localparam jsu_pkg::res_t WANT_FF      = '{8'hFF, 1'b1, 1'b0, jsu_pkg::ERR_NONE,   1'b1};

    localparam logic [7:0] ESC_LETTERS [8] = '{
        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH, jsu_pkg::CH_LN,
        jsu_pkg::CH_LR, jsu_pkg::CH_LT, jsu_pkg::CH_LB, jsu_pkg::CH_LF
    };

    // Directed opening: end of data as the very first item, byte extremes,
    // a bad escape, a surrogate pair in mixed hex case, a held code thrown
    // away by end of data, a bare closing quote, and a bad hex digit.
    localparam int DIR_N = 28;
    localparam feed_t DIRECTED [DIR_N] = '{
        '{8'hFF,             1'b1, 1'b1, WANT_EOD},          // byte ignored under end of data
        '{8'h00,             1'b0, 1'b1, WANT_NUL},
        '{8'hFF,             1'b0, 1'b1, WANT_FF},
        '{jsu_pkg::CH_BSL,   1'b0, 1'b0, jsu_pkg::RES_ZERO},
        '{"q",               1'b0, 1'b1, WANT_BAD_ESC},
        '{jsu_pkg::CH_BSL,   1'b0, 1'b0, jsu_pkg::RES_ZERO}, // high surrogate D83D, held
        '{jsu_pkg::CH_LU,    1'b0, 1'b0, jsu_pkg::RES_ZERO},
        '{"D",               1'b0, 1'b0, jsu_pkg::RES_ZERO},
        '{"8",               1'b0, 1'b0, jsu_pkg::RES_ZERO},
        '{"3",               1'b0, 1'b0, jsu_pkg::RES_ZERO},
        '{"D",               1'b0, 1'b0, jsu_pkg::RES_ZERO},
        '{jsu_pkg::CH_BSL,   1'b0, 1'b0, jsu_pkg::RES_ZERO}, // low surrogate dE00 merges
        '{jsu_pkg::CH_LU,    1'b0, 1'b0, jsu_pkg::RES_ZERO},
        '{"d",               1'b0, 1'b0, jsu_pkg::RES_ZERO},
        '{"E",               1'b0, 1'b0, jsu_pkg::RES_ZERO},
        '{"0",               1'b0, 1'b0, jsu_pkg::RES_ZERO},
        '{"0",               1'b0, 1'b0, jsu_pkg::RES_ZERO},
        '{jsu_pkg::CH_BSL,   1'b0, 1'b0, jsu_pkg::RES_ZERO}, // FfFf, held
        '{jsu_pkg::CH_LU,    1'b0, 1'b0, jsu_pkg::RES_ZERO},
        '{"F",               1'b0, 1'b0, jsu_pkg::RES_ZERO},
        '{"f",               1'b0, 1'b0, jsu_pkg::RES_ZERO},
        '{"F",               1'b0, 1'b0, jsu_pkg::RES_ZERO},
        '{"f",               1'b0, 1'b0, jsu_pkg::RES_ZERO},
        '{8'h00,             1'b1, 1'b1, WANT_EOD},          // drops the held code silently
        '{jsu_pkg::CH_QUOTE, 1'b0, 1'b1, WANT_DONE},
        '{jsu_pkg::CH_BSL,   1'b0, 1'b0, jsu_pkg::RES_ZERO},
        '{jsu_pkg::CH_LU,    1'b0, 1'b0, jsu_pkg::RES_ZERO},
        '{"x",               1'b0, 1'b1, WANT_BAD_HEX}
    };

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte     = 8'h00;
    logic       end_of_data = 1'b0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [1:0] error_code;
    logic       last_of_run;

    always #HALF_PERIOD clk = ~clk;

    json_string_unescape_utf8_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .end_of_data (end_of_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .string_done (string_done),
        .error_code  (error_code),
        .last_of_run (last_of_run)
    );

    // ------------------------------------------------------------------
    // Predictor: parser state and the results of the byte just fed
    // ------------------------------------------------------------------
    jsu_pkg::mode_t mode;
    logic [1:0]     hex_cnt;
    logic [15:0]    acc;
    logic [15:0]    held;
    logic           held_v;
    jsu_pkg::res_t  step_res[$];

    int n_done;
    int n_errors;
    int n_pairs;

    function automatic void clear_parser();
        mode    = jsu_pkg::MODE_PLAIN;
        hex_cnt = '0;
        acc     = '0;
        held    = '0;
        held_v  = 1'b0;
    endfunction

    function automatic void emit(logic [7:0] b, logic bv, logic done, logic [1:0] err);
        jsu_pkg::res_t r;
        r.out_byte    = b;
        r.byte_valid  = bv;
        r.string_done = done;
        r.error_code  = err;
        r.last_of_run = 1'b0;
        step_res.push_back(r);
    endfunction

    function automatic void emit_byte(logic [7:0] b);
        emit(b, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
    endfunction

    // Encode one code point as UTF-8, shortest form.
    function automatic void emit_utf8(logic [20:0] cp);
        if (cp < 21'h80)
        begin
            emit_byte(cp[7:0]);
        end
        else if (cp < 21'h800)
        begin
            emit_byte(jsu_pkg::U8_LEAD2 | {3'b000, cp[10:6]});
            emit_byte(jsu_pkg::U8_CONT  | {2'b00, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            emit_byte(jsu_pkg::U8_LEAD3 | {4'b0000, cp[15:12]});
            emit_byte(jsu_pkg::U8_CONT  | {2'b00, cp[11:6]});
            emit_byte(jsu_pkg::U8_CONT  | {2'b00, cp[5:0]});
        end
        else
        begin
            emit_byte(jsu_pkg::U8_LEAD4 | {5'b00000, cp[20:18]});
            emit_byte(jsu_pkg::U8_CONT  | {2'b00, cp[17:12]});
            emit_byte(jsu_pkg::U8_CONT  | {2'b00, cp[11:6]});
            emit_byte(jsu_pkg::U8_CONT  | {2'b00, cp[5:0]});
        end
    endfunction

    function automatic void flush_held();
        if (held_v)
        begin
            emit_utf8({5'b00000, held});
            held_v = 1'b0;
            held   = '0;
        end
    endfunction

    // Any error drops a held code and starts a fresh string.
    function automatic void abort(logic [1:0] err);
        clear_parser();
        emit(8'h00, 1'b0, 1'b0, err);
        n_errors++;
    endfunction

    // {valid, nibble} of a hex digit of either case.
    function automatic logic [4:0] hex_nibble(logic [7:0] c);
        if (c >= jsu_pkg::CH_0 && c <= jsu_pkg::CH_9)
            return {1'b1, 4'(c - jsu_pkg::CH_0)};
        if (c >= jsu_pkg::CH_UA && c <= jsu_pkg::CH_UF)
            return {1'b1, 4'(c - jsu_pkg::CH_UA + 8'd10)};
        if (c >= jsu_pkg::CH_LA && c <= jsu_pkg::CH_LF)
            return {1'b1, 4'(c - jsu_pkg::CH_LA + 8'd10)};
        return 5'b0;
    endfunction

    // {valid, character} for the letter after a backslash; \u is not included.
    function automatic logic [8:0] unescape(logic [7:0] c);
        case (c)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH: return {1'b1, c};
            jsu_pkg::CH_LN: return {1'b1, jsu_pkg::CH_NL};
            jsu_pkg::CH_LR: return {1'b1, jsu_pkg::CH_CR};
            jsu_pkg::CH_LT: return {1'b1, jsu_pkg::CH_TAB};
            jsu_pkg::CH_LB: return {1'b1, jsu_pkg::CH_BS};
            jsu_pkg::CH_LF: return {1'b1, jsu_pkg::CH_FF};
            default:        return 9'b0;
        endcase
    endfunction

    // Advance the parser by one byte and leave its results in step_res.
    function automatic void unescape_step(logic [7:0] b, logic eod);
        logic [8:0]    esc;
        logic [4:0]    nib;
        logic [15:0]   code;
        logic [20:0]   cp;
        jsu_pkg::res_t tail;
        step_res.delete();
        if (eod)
        begin
            abort(jsu_pkg::ERR_EOD);
        end
        else if (mode == jsu_pkg::MODE_ESC)
        begin
            esc = unescape(b);
            if (b == jsu_pkg::CH_LU)
            begin
                mode    = jsu_pkg::MODE_HEX;
                hex_cnt = '0;
                acc     = '0;
            end
            else if (esc[8])
            begin
                flush_held();
                emit_byte(esc[7:0]);
                mode = jsu_pkg::MODE_PLAIN;
            end
            else
            begin
                abort(jsu_pkg::ERR_ESCAPE);
            end
        end
        else if (mode == jsu_pkg::MODE_HEX)
        begin
            nib = hex_nibble(b);
            if (!nib[4])
            begin
                abort(jsu_pkg::ERR_HEX);
            end
            else if (hex_cnt == 2'd3)
            begin
                code = {acc[11:0], nib[3:0]};
                // Merge only a held high half with a following low half.
                if (held_v && held >= jsu_pkg::HI_SUR_MIN && held <= jsu_pkg::HI_SUR_MAX
                    && code >= jsu_pkg::LO_SUR_MIN && code <= jsu_pkg::LO_SUR_MAX)
                begin
                    cp = jsu_pkg::SUPP_BASE + {1'b0, held[9:0], 10'b0} + {11'b0, code[9:0]};
                    held_v = 1'b0;
                    held   = '0;
                    emit_utf8(cp);
                    n_pairs++;
                end
                else
                begin
                    flush_held();
                    held   = code;
                    held_v = 1'b1;
                end
                mode    = jsu_pkg::MODE_PLAIN;
                hex_cnt = '0;
                acc     = '0;
            end
            else
            begin
                acc     = {acc[11:0], nib[3:0]};
                hex_cnt = hex_cnt + 2'd1;
            end
        end
        else if (b == jsu_pkg::CH_BSL)
        begin
            mode = jsu_pkg::MODE_ESC;
        end
        else
        begin
            flush_held();
            if (b == jsu_pkg::CH_QUOTE)
            begin
                emit(8'h00, 1'b0, 1'b1, jsu_pkg::ERR_NONE);
                clear_parser();
                n_done++;
            end
            else
            begin
                emit_byte(b);
            end
        end
        // Tag the final result of this byte.
        if (step_res.size() > 0)
        begin
            tail = step_res.pop_back();
            tail.last_of_run = 1'b1;
            step_res.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus build: directed rows first, then random tokens
    // ------------------------------------------------------------------
    feed_t stim[$];

    function automatic void push_byte(logic [7:0] b, logic eod);
        feed_t f;
        f.b     = b;
        f.eod   = eod;
        f.typed = 1'b0;
        f.want  = jsu_pkg::RES_ZERO;
        stim.push_back(f);
    endfunction

    // Hex digit character, letters in random case.
    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10)
            return jsu_pkg::CH_0 + {4'b0, n};
        return ($urandom_range(1) ? jsu_pkg::CH_UA : jsu_pkg::CH_LA) + {4'b0, n} - 8'd10;
    endfunction

    function automatic void push_hex_digits(logic [15:0] code, int count);
        for (int i = 3; i > 3 - count; i--)
            push_byte(hex_char(code[4*i +: 4]), 1'b0);
    endfunction

    function automatic void push_u_escape(logic [15:0] code);
        push_byte(jsu_pkg::CH_BSL, 1'b0);
        push_byte(jsu_pkg::CH_LU, 1'b0);
        push_hex_digits(code, 4);
    endfunction

    function automatic logic [15:0] random_code();
        case ($urandom_range(4))
            0:       return 16'($urandom_range(16'h007F));
            1:       return 16'($urandom_range(16'h07FF, 16'h0080));
            2:       return 16'($urandom_range(16'hFFFF));
            3:       return 16'($urandom_range(jsu_pkg::HI_SUR_MAX, jsu_pkg::HI_SUR_MIN));
            default: return 16'($urandom_range(jsu_pkg::LO_SUR_MAX, jsu_pkg::LO_SUR_MIN));
        endcase
    endfunction

    function automatic void build_stimulus();
        int          pick;
        logic [7:0]  b;
        logic [4:0]  nib;
        logic [8:0]  esc;
        foreach (DIRECTED[i])
            stim.push_back(DIRECTED[i]);
        // Mostly well-formed pieces of string with random content; about one
        // token in eight is noise that ends the string with an error.
        while (stim.size() < DIR_N + RAND_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                push_byte(8'($urandom_range(255)), 1'b0);
            end
            else if (pick < 45)
            begin
                push_byte(jsu_pkg::CH_BSL, 1'b0);
                push_byte(ESC_LETTERS[$urandom_range(7)], 1'b0);
            end
            else if (pick < 67)
            begin
                push_u_escape(random_code());
            end
            else if (pick < 79)
            begin
                push_u_escape(16'($urandom_range(jsu_pkg::HI_SUR_MAX, jsu_pkg::HI_SUR_MIN)));
                push_u_escape(16'($urandom_range(jsu_pkg::LO_SUR_MAX, jsu_pkg::LO_SUR_MIN)));
            end
            else if (pick < 87)
            begin
                push_byte(jsu_pkg::CH_QUOTE, 1'b0);
            end
            else if (pick < 91)
            begin
                // Letter after a backslash that is no escape and not u.
                do
                begin
                    b   = 8'($urandom_range(255));
                    esc = unescape(b);
                end
                while (esc[8] || b == jsu_pkg::CH_LU);
                push_byte(jsu_pkg::CH_BSL, 1'b0);
                push_byte(b, 1'b0);
            end
            else if (pick < 95)
            begin
                // Non-hex byte after zero to three good digits.
                do
                begin
                    b   = 8'($urandom_range(255));
                    nib = hex_nibble(b);
                end
                while (nib[4]);
                push_byte(jsu_pkg::CH_BSL, 1'b0);
                push_byte(jsu_pkg::CH_LU, 1'b0);
                push_hex_digits(16'($urandom_range(16'hFFFF)), $urandom_range(3));
                push_byte(b, 1'b0);
            end
            else
            begin
                // End of data in plain text, after a backslash, or inside \u.
                case ($urandom_range(2))
                    0: ;
                    1: push_byte(jsu_pkg::CH_BSL, 1'b0);
                    default:
                    begin
                        push_byte(jsu_pkg::CH_BSL, 1'b0);
                        push_byte(jsu_pkg::CH_LU, 1'b0);
                        push_hex_digits(16'($urandom_range(16'hFFFF)), $urandom_range(3));
                    end
                endcase
                push_byte(8'($urandom_range(255)), 1'b1);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side: present rows in order, predict each one on its transfer
    // ------------------------------------------------------------------
    jsu_pkg::res_t decoded_due[$];     // results still owed by the unit, oldest first
    int            send_idx = 0;       // row on the bus, or next to present
    logic          calm     = 1'b0;    // no idling on either side while set
    feed_t         cur;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            // Transfer: advance the predictor and queue what this byte owes.
            if (in_valid && in_ready)
            begin
                cur = stim[send_idx];
                unescape_step(cur.b, cur.eod);
                if (cur.typed)
                    decoded_due.push_back(cur.want);
                else
                    foreach (step_res[i])
                        decoded_due.push_back(step_res[i]);
                send_idx++;
            end
            calm <= (send_idx >= CALM_LO && send_idx < CALM_HI);
            // Hold a pending row; otherwise present the next one or idle.
            if (!in_valid || in_ready)
            begin
                if (send_idx < stim.size() && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    in_valid    <= 1'b1;
                    in_byte     <= stim[send_idx].b;
                    end_of_data <= stim[send_idx].eod;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: random back-pressure and the result check
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    int            mismatches = 0;
    int            n_checked  = 0;
    jsu_pkg::res_t owed;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (decoded_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result byte %02h err %0d",
                                          out_byte, error_code));
            end
            else
            begin
                owed = decoded_due.pop_front();
                if (out_byte !== owed.out_byte)
                    report_mismatch($sformatf("result %0d out_byte %02h, want %02h",
                                              n_checked, out_byte, owed.out_byte));
                if (byte_valid !== owed.byte_valid)
                    report_mismatch($sformatf("result %0d byte_valid %b, want %b",
                                              n_checked, byte_valid, owed.byte_valid));
                if (string_done !== owed.string_done)
                    report_mismatch($sformatf("result %0d string_done %b, want %b",
                                              n_checked, string_done, owed.string_done));
                if (error_code !== owed.error_code)
                    report_mismatch($sformatf("result %0d error_code %0d, want %0d",
                                              n_checked, error_code, owed.error_code));
                if (last_of_run !== owed.last_of_run)
                    report_mismatch($sformatf("result %0d last_of_run %b, want %b",
                                              n_checked, last_of_run, owed.last_of_run));
            end
            n_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing: reset once, run everything, drain, verdict
    // ------------------------------------------------------------------
    initial
    begin
        n_done   = 0;
        n_errors = 0;
        n_pairs  = 0;
        clear_parser();
        build_stimulus();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        // Wait for every row to transfer and every owed result to arrive.
        while (send_idx < stim.size() || decoded_due.size() != 0)
            @(posedge clk);
        // Stay a little longer to catch any stray result.
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("fed %0d bytes, checked %0d results", send_idx, n_checked);
        $display("strings closed %0d, errors flagged %0d, surrogate pairs merged %0d",
                 n_done, n_errors, n_pairs);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Stop a hung run.
    initial
    begin
        #(WATCHDOG_NS);
        $display("timeout with %0d results still owed", decoded_due.size());
        $display("FAIL");
        $finish;
    end

endmodule
